FILE: rtl/pkbe_pkg.sv
// Shared constants, types and control structures of the PackBits encoder.
package pkbe_pkg;

  localparam int unsigned MAX_LITERAL = 32;
  localparam int unsigned MAX_RUN     = 128;

  localparam int unsigned LIT_AW = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;
  localparam int unsigned LC_W   = $clog2(MAX_LITERAL + 1);
  localparam int unsigned RUN_W  = 8;

  localparam logic [7:0] END_CODE     = 8'd128;
  localparam logic [8:0] RUN_HDR_BASE = 9'd257;

  typedef logic [7:0]        byte_t;
  typedef logic [LC_W-1:0]   lit_cnt_t;
  typedef logic [LIT_AW-1:0] lit_addr_t;
  typedef logic [RUN_W-1:0]  run_len_t;

  // Source of the code byte that the datapath presents.
  typedef enum logic [2:0] {
    SEL_RUN_HDR  = 3'd0,
    SEL_HELD     = 3'd1,
    SEL_LIT_HDR  = 3'd2,
    SEL_LIT_DATA = 3'd3,
    SEL_END      = 3'd4
  } out_sel_e;

  // Controller to datapath.
  typedef struct packed {
    logic     load;
    logic     run_inc;
    logic     set_held;
    logic     run_set2;
    logic     run_set3;
    logic     hc_set2;
    logic     hc_dec;
    logic     push;
    logic     clr_run;
    logic     fl_start;
    logic     fl_next;
    logic     clr_lc;
    logic     clr_all;
    out_sel_e sel;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic       fin;
    logic       run_nz;
    logic       match;
    logic       run_lt_max;
    logic [1:0] hc;
    logic       lc_zero;
    logic       lc_fits2;
    logic       lc_fill;
    logic       fl_last;
  } dp_sts_t;

  // Controller to output stage.
  typedef struct packed {
    logic emit;
    logic end_mark;
    logic release_pend;
  } out_cmd_t;

  // Output stage to controller.
  typedef struct packed {
    logic emit_ready;
    logic release_ready;
  } out_sts_t;

endpackage

FILE: rtl/pkbe_if.sv
// Valid/ready stream interfaces for raw input bytes and for code bytes.
interface pkbe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface pkbe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       end_marker;
  logic       last_of_item;

  modport source (output valid, output code_byte, output end_marker,
                  output last_of_item, input ready);
  modport sink   (input valid, input code_byte, input end_marker,
                  input last_of_item, output ready);
endinterface

FILE: rtl/pkbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pkbe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/pkbe_datapath.sv
// Encoder datapath: held byte, run and literal counters, literal store, code byte mux.
module pkbe_datapath import pkbe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  byte_t   data_byte_i,
  input  logic    final_byte_i,
  input  dp_cmd_t cmd_i,
  output dp_sts_t sts_o,
  output byte_t   code_byte_o
);

  byte_t     b_q;
  logic      fin_q;
  byte_t     held_q;
  logic [1:0] hc_q;
  run_len_t  run_q;
  lit_cnt_t  lc_q;
  lit_cnt_t  idx_q;
  byte_t     rdata;
  lit_addr_t raddr;
  logic [8:0] run_hdr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      b_q   <= data_byte_i;
      fin_q <= final_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      hc_q   <= '0;
      run_q  <= '0;
      lc_q   <= '0;
      idx_q  <= '0;
    end else begin
      if (cmd_i.clr_all) begin
        held_q <= '0;
      end else if (cmd_i.set_held) begin
        held_q <= b_q;
      end

      if (cmd_i.clr_all || cmd_i.run_set2 || cmd_i.run_set3) begin
        hc_q <= 2'd0;
      end else if (cmd_i.set_held) begin
        hc_q <= 2'd1;
      end else if (cmd_i.hc_set2) begin
        hc_q <= 2'd2;
      end else if (cmd_i.hc_dec) begin
        hc_q <= hc_q - 2'd1;
      end

      if (cmd_i.clr_all || cmd_i.clr_run) begin
        run_q <= '0;
      end else if (cmd_i.run_set2) begin
        run_q <= RUN_W'(2);
      end else if (cmd_i.run_set3) begin
        run_q <= RUN_W'(3);
      end else if (cmd_i.run_inc) begin
        run_q <= run_q + RUN_W'(1);
      end

      if (cmd_i.clr_all || cmd_i.clr_lc) begin
        lc_q <= '0;
      end else if (cmd_i.push) begin
        lc_q <= lc_q + LC_W'(1);
      end

      if (cmd_i.fl_start) begin
        idx_q <= LC_W'(1);
      end else if (cmd_i.fl_next) begin
        idx_q <= idx_q + LC_W'(1);
      end
    end
  end

  assign raddr = cmd_i.fl_start ? '0 : idx_q[LIT_AW-1:0];

  pkbe_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LITERAL)
  ) u_lit_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (lc_q[LIT_AW-1:0]),
    .wdata_i (held_q),
    .re_i    (cmd_i.fl_start || cmd_i.fl_next),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign run_hdr = RUN_HDR_BASE - 9'(run_q);

  always_comb begin
    case (cmd_i.sel)
      SEL_RUN_HDR:  code_byte_o = run_hdr[7:0];
      SEL_HELD:     code_byte_o = held_q;
      SEL_LIT_HDR:  code_byte_o = 8'(lc_q) - 8'd1;
      SEL_LIT_DATA: code_byte_o = rdata;
      SEL_END:      code_byte_o = END_CODE;
      default:      code_byte_o = END_CODE;
    endcase
  end

  always_comb begin
    sts_o.fin        = fin_q;
    sts_o.run_nz     = (run_q != '0);
    sts_o.match      = (b_q == held_q);
    sts_o.run_lt_max = (run_q < RUN_W'(MAX_RUN));
    sts_o.hc         = hc_q;
    sts_o.lc_zero    = (lc_q == '0);
    sts_o.lc_fits2   = (({1'b0, lc_q} + (LC_W + 1)'(2)) <= (LC_W + 1)'(MAX_LITERAL));
    sts_o.lc_fill    = (lc_q == LC_W'(MAX_LITERAL - 1));
    sts_o.fl_last    = (idx_q == lc_q);
  end

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (lc_q < LC_W'(MAX_LITERAL)))
    else $error("literal push into a full store");

  a_hc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hc_q != 2'd3)
    else $error("held count out of range");

  a_flush_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fl_next |-> (idx_q < lc_q))
    else $error("literal read past the fill count");

endmodule

FILE: rtl/pkbe_out_stage.sv
// Output stage: one pending code byte and the output register, so the last word is marked.
module pkbe_out_stage import pkbe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  out_cmd_t          ocmd_i,
  input  byte_t             code_byte_i,
  output out_sts_t          osts_o,
  pkbe_out_if.source        out_o
);

  logic  pend_v_q;
  byte_t pend_byte_q;
  logic  pend_end_q;
  logic  ov_q;
  byte_t ob_q;
  logic  oe_q;
  logic  ol_q;
  logic  out_free;
  logic  emit_fire;
  logic  rel_fire;
  logic  move;

  assign out_free  = !ov_q || out_o.ready;
  assign osts_o.emit_ready    = !pend_v_q || out_free;
  assign osts_o.release_ready = !pend_v_q || out_free;
  assign emit_fire = ocmd_i.emit && osts_o.emit_ready;
  assign rel_fire  = ocmd_i.release_pend && osts_o.release_ready;
  // The pending word moves out once the next word arrives or the item ends.
  assign move      = pend_v_q && (emit_fire || rel_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      if (emit_fire) begin
        pend_v_q <= 1'b1;
      end else if (rel_fire) begin
        pend_v_q <= 1'b0;
      end
      if (move) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      pend_byte_q <= code_byte_i;
      pend_end_q  <= ocmd_i.end_mark;
    end
    if (move) begin
      ob_q <= pend_byte_q;
      oe_q <= pend_end_q;
      ol_q <= rel_fire;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.code_byte    = ob_q;
  assign out_o.end_marker   = oe_q;
  assign out_o.last_of_item = ol_q;

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && oe_q) |-> ol_q)
    else $error("end marker word not marked as last of item");

endmodule

FILE: rtl/pkbe_ctrl.sv
// Encoder controller: sequences run, literal and end-marker words for each input byte.
module pkbe_ctrl import pkbe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_sts_t  sts_i,
  input  out_sts_t osts_i,
  output dp_cmd_t  cmd_o,
  output out_cmd_t ocmd_o
);

  typedef enum logic [9:0] {
    S_IDLE       = 10'b00_0000_0001,
    S_DECIDE     = 10'b00_0000_0010,
    S_RUN_HDR    = 10'b00_0000_0100,
    S_RUN_BYTE   = 10'b00_0000_1000,
    S_COMMIT     = 10'b00_0001_0000,
    S_FLUSH_HDR  = 10'b00_0010_0000,
    S_FLUSH_DATA = 10'b00_0100_0000,
    S_FIN        = 10'b00_1000_0000,
    S_END        = 10'b01_0000_0000,
    S_SPARE      = 10'b10_0000_0000
  } state_e;

  typedef enum logic [1:0] {
    RET_COMMIT = 2'd0,
    RET_MAIN   = 2'd1,
    RET_END    = 2'd2
  } ret_e;

  state_e state_q, state_d;
  ret_e   ret_q, ret_d;
  logic   fin_phase_q, fin_phase_d;
  logic   go;
  state_e after_main;
  state_e ret_state;

  assign go = osts_i.emit_ready;
  assign after_main = sts_i.fin ? S_FIN : S_IDLE;

  always_comb begin
    case (ret_q)
      RET_COMMIT: ret_state = S_COMMIT;
      RET_MAIN:   ret_state = after_main;
      RET_END:    ret_state = S_END;
      default:    ret_state = S_END;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    fin_phase_d = fin_phase_q;
    cmd_o       = '0;
    cmd_o.sel   = SEL_END;
    ocmd_o      = '0;
    in_ready_o  = 1'b0;

    case (state_q)
      S_IDLE: begin
        ocmd_o.release_pend = 1'b1;
        in_ready_o = osts_i.release_ready;
        if (in_valid_i && osts_i.release_ready) begin
          cmd_o.load  = 1'b1;
          fin_phase_d = 1'b0;
          state_d     = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (sts_i.run_nz) begin
          if (sts_i.match && sts_i.run_lt_max) begin
            cmd_o.run_inc = 1'b1;
            state_d = after_main;
          end else begin
            state_d = S_RUN_HDR;
          end
        end else if (sts_i.hc == 2'd0) begin
          cmd_o.set_held = 1'b1;
          state_d = after_main;
        end else if (sts_i.match) begin
          if (sts_i.hc == 2'd1) begin
            if (sts_i.lc_zero) begin
              cmd_o.run_set2 = 1'b1;
              state_d = after_main;
            end else if (sts_i.lc_fits2) begin
              cmd_o.hc_set2 = 1'b1;
              state_d = after_main;
            end else begin
              // A pair that does not fit ends the literal and becomes a repeat of two.
              cmd_o.run_set2 = 1'b1;
              ret_d   = RET_MAIN;
              state_d = S_FLUSH_HDR;
            end
          end else begin
            if (MAX_RUN >= 3) begin
              cmd_o.run_set3 = 1'b1;
            end else begin
              // With repeats capped at two, the first held copy joins the literal.
              cmd_o.push     = 1'b1;
              cmd_o.run_set2 = 1'b1;
            end
            ret_d   = RET_MAIN;
            state_d = S_FLUSH_HDR;
          end
        end else begin
          state_d = S_COMMIT;
        end
      end

      S_RUN_HDR: begin
        ocmd_o.emit = 1'b1;
        cmd_o.sel   = SEL_RUN_HDR;
        if (go) begin
          state_d = S_RUN_BYTE;
        end
      end

      S_RUN_BYTE: begin
        ocmd_o.emit = 1'b1;
        cmd_o.sel   = SEL_HELD;
        if (go) begin
          cmd_o.clr_run = 1'b1;
          if (fin_phase_q) begin
            state_d = S_END;
          end else begin
            cmd_o.set_held = 1'b1;
            state_d = after_main;
          end
        end
      end

      S_COMMIT: begin
        if (sts_i.hc == 2'd0) begin
          if (fin_phase_q) begin
            ret_d   = RET_END;
            state_d = S_FLUSH_HDR;
          end else begin
            cmd_o.set_held = 1'b1;
            state_d = after_main;
          end
        end else begin
          cmd_o.push   = 1'b1;
          cmd_o.hc_dec = 1'b1;
          if (sts_i.lc_fill) begin
            ret_d   = RET_COMMIT;
            state_d = S_FLUSH_HDR;
          end
        end
      end

      S_FLUSH_HDR: begin
        if (sts_i.lc_zero) begin
          state_d = ret_state;
        end else begin
          ocmd_o.emit = 1'b1;
          cmd_o.sel   = SEL_LIT_HDR;
          if (go) begin
            cmd_o.fl_start = 1'b1;
            state_d = S_FLUSH_DATA;
          end
        end
      end

      S_FLUSH_DATA: begin
        ocmd_o.emit = 1'b1;
        cmd_o.sel   = SEL_LIT_DATA;
        if (go) begin
          if (sts_i.fl_last) begin
            cmd_o.clr_lc = 1'b1;
            state_d = ret_state;
          end else begin
            cmd_o.fl_next = 1'b1;
          end
        end
      end

      S_FIN: begin
        fin_phase_d = 1'b1;
        state_d = sts_i.run_nz ? S_RUN_HDR : S_COMMIT;
      end

      S_END: begin
        ocmd_o.emit     = 1'b1;
        ocmd_o.end_mark = 1'b1;
        cmd_o.sel       = SEL_END;
        if (go) begin
          cmd_o.clr_all = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= RET_END;
      fin_phase_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      fin_phase_q <= fin_phase_d;
    end
  end

  a_decide_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE) |-> $past(in_valid_i && in_ready_o))
    else $error("decision step without an accepted word");

  a_flush_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH_DATA) |-> !sts_i.lc_zero)
    else $error("literal data step with an empty literal store");

endmodule

FILE: rtl/packbits_run_length_encoder.sv
// PackBits run-length encoder top level: controller, datapath and output stage.
// A raw byte that only extends a repeat, opens one or pairs with the held byte passes
// through accept and decision, then the controller returns to idle for the next byte
// unless this one was final. A byte that moves held copies into the literal store pushes
// them one by one in the commit state and then takes their place. Every code byte adds a
// step to the sequence: header and held byte for a repeat, header and stored bytes for a
// literal, read from the 32-entry literal store one byte a cycle through its single read
// port while the output accepts them, and the end marker after the final byte. A byte that
// closes the stream also passes a step choosing its flush path and moves its held copies
// as above; a flush that finds the literal empty emits nothing. Code bytes leave one word
// behind the controller, so the last word of each input byte can carry last_of_item;
// output back-pressure stalls the sequence. There is no clearing pass after reset.
module packbits_run_length_encoder import pkbe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  pkbe_in_if.sink    in_i,
  pkbe_out_if.source out_o
);

  dp_cmd_t  dp_cmd;
  dp_sts_t  dp_sts;
  out_cmd_t out_cmd;
  out_sts_t out_sts;
  byte_t    code_byte;
  logic     in_ready;

  assign in_i.ready = in_ready;

  pkbe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (dp_sts),
    .osts_i     (out_sts),
    .cmd_o      (dp_cmd),
    .ocmd_o     (out_cmd)
  );

  pkbe_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .data_byte_i  (in_i.data_byte),
    .final_byte_i (in_i.final_byte),
    .cmd_i        (dp_cmd),
    .sts_o        (dp_sts),
    .code_byte_o  (code_byte)
  );

  pkbe_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ocmd_i      (out_cmd),
    .code_byte_i (code_byte),
    .osts_o      (out_sts),
    .out_o       (out_o)
  );

endmodule
